// ===== sv/gemw_pkg.sv =====
package gemw_pkg;

   // Default grid edge length in cells
   localparam int GRID_CELLS_DEF = 64;

   localparam int COORD_W     = 6;
   localparam int VALUE_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_YAW_COSINE  = 3'd0,
      CSR_YAW_SINE    = 3'd1,
      CSR_SHIFT_X     = 3'd2,
      CSR_SHIFT_Y     = 3'd3,
      CSR_CELLS_PER_M = 3'd4
   } csr_index_type;

   localparam logic signed [CSR_DATA_W-1:0] YAW_COSINE_RST  = 16'sd16384;
   localparam logic signed [CSR_DATA_W-1:0] YAW_SINE_RST    = 16'sd0;
   localparam logic signed [CSR_DATA_W-1:0] SHIFT_X_RST     = 16'sd0;
   localparam logic signed [CSR_DATA_W-1:0] SHIFT_Y_RST     = 16'sd0;
   localparam logic        [CSR_DATA_W-1:0] CELLS_PER_M_RST = 16'd1280;

   // Request kinds
   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic               req_type;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic               occupied;
   } req_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] warped_value;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WARP,
      ST_DONE
   } warp_state_type;

endpackage

// ===== sv/grid_ego_motion_warp.sv =====
// Ego-motion warp of a square binary occupancy grid. A write word stores one cell of the
// previous frame (ignored when a coordinate lies outside the grid). A sample word names
// an output cell; the block maps it back through the configured rotation (cosine/sine,
// Q2.14) and translation (meters Q8.8 times cells per meter) to a source point and
// returns the bilinear blend of the four cells around it, Q1.15, with cells outside the
// grid reading as zero. A sample occupies the block from acceptance until it can accept
// again: 16 steps run on one shared 17x18 multiplier (two offset products, eight partial
// products of the rotation, four blend weights) while the single grid memory read port
// fetches the four neighbors, then the done state loads the result register once it is
// free. The finished result waits in that register, so the next word is accepted while
// it is still stalled. After reset the grid memory is swept to zero, one cell per cycle,
// over all 4**ceil(log2(GRID_CELLS)) cells (4096 at the default 64x64 grid); no word is
// accepted during the sweep, while configuration writes are taken at any time.
// Configuration is meant to change only while the block is idle.
module grid_ego_motion_warp
   import gemw_pkg::*;
#(
   parameter int GRID_CELLS = GRID_CELLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IW    = $clog2(GRID_CELLS);
   localparam int AW    = 2 * IW;
   localparam int DEPTH = 1 << AW;
   localparam int SXW   = 50;   // Q.30 source coordinate accumulator
   localparam int PW    = 35;   // multiplier product
   localparam int UW    = 34;   // Q18.16 shifted destination coordinate
   localparam int ACCW  = 31;   // blend sum, at most 2**30

   // Sequencer steps: multiply issued at step t is consumed at step t+1
   localparam logic [3:0] STEP_MX     = 4'd0;
   localparam logic [3:0] STEP_MY     = 4'd1;
   localparam logic [3:0] STEP_CUL    = 4'd2;
   localparam logic [3:0] STEP_CUH    = 4'd3;
   localparam logic [3:0] STEP_SUL    = 4'd4;
   localparam logic [3:0] STEP_SUH    = 4'd5;
   localparam logic [3:0] STEP_SVL    = 4'd6;
   localparam logic [3:0] STEP_SVH    = 4'd7;
   localparam logic [3:0] STEP_CVL    = 4'd8;
   localparam logic [3:0] STEP_CVH    = 4'd9;
   localparam logic [3:0] STEP_SETTLE = 4'd10;
   localparam logic [3:0] STEP_W00    = 4'd11;
   localparam logic [3:0] STEP_W10    = 4'd12;
   localparam logic [3:0] STEP_W01    = 4'd13;
   localparam logic [3:0] STEP_W11    = 4'd14;
   localparam logic [3:0] STEP_LAST   = 4'd15;

   // Control state
   warp_state_type state_ff, state_in;
   logic [3:0]     step_ff, step_in;
   logic [AW-1:0]  clr_ptr_ff, clr_ptr_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Configuration
   logic signed [CSR_DATA_W-1:0] yaw_cosine_ff, yaw_cosine_in;
   logic signed [CSR_DATA_W-1:0] yaw_sine_ff, yaw_sine_in;
   logic signed [CSR_DATA_W-1:0] shift_x_ff, shift_x_in;
   logic signed [CSR_DATA_W-1:0] shift_y_ff, shift_y_in;
   logic        [CSR_DATA_W-1:0] cells_per_m_ff, cells_per_m_in;

   // Datapath
   logic [COORD_W-1:0]  x_ff, x_in;
   logic [COORD_W-1:0]  y_ff, y_in;
   logic signed [UW-1:0]  u_ff, u_in;
   logic signed [UW-1:0]  v_ff, v_in;
   logic signed [SXW-1:0] sx_ff, sx_in;
   logic signed [SXW-1:0] sy_ff, sy_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic [ACCW-1:0]       acc_ff, acc_in;
   logic                  inside_ff, inside_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   // Grid memory
   logic          grid_mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic          cell_ff;

   // Sequencer handshakes
   logic start;
   logic load_rsp;
   logic req_accept;
   logic wr_inside;

   // Multiplier operands and derived values
   logic signed [16:0]    mul_a;
   logic signed [17:0]    mul_b;
   logic signed [SXW-1:0] p_ext;
   logic signed [SXW-1:0] p_term;
   logic signed [19:0]    x0;
   logic signed [19:0]    y0;
   logic [14:0]           fx;
   logic [14:0]           fy;
   logic [15:0]           gx;
   logic [15:0]           gy;
   logic [1:0]            nbr;
   logic signed [20:0]    nx;
   logic signed [20:0]    ny;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign wr_inside  = (32'(req_word.cell_x) < GRID_CELLS) &&
                       (32'(req_word.cell_y) < GRID_CELLS);

   //-------------------------------------------------------------------------
   // Sequencer
   //-------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      clr_ptr_in = clr_ptr_ff;
      req_stall  = 1'b1;
      mem_we     = 1'b0;
      mem_waddr  = clr_ptr_ff;
      mem_wdata  = 1'b0;
      start      = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            // sweep zeros through the grid, one cell a cycle
            mem_we     = 1'b1;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_word.req_type == REQ_SAMPLE) begin
                  start    = 1'b1;
                  step_in  = STEP_MX;
                  state_in = ST_WARP;
               end else if (wr_inside) begin
                  mem_we    = 1'b1;
                  mem_waddr = {IW'(req_word.cell_y), IW'(req_word.cell_x)};
                  mem_wdata = req_word.occupied;
               end
            end
         end
         ST_WARP: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   //-------------------------------------------------------------------------
   // Configuration writes
   //-------------------------------------------------------------------------
   always_comb begin
      yaw_cosine_in  = yaw_cosine_ff;
      yaw_sine_in    = yaw_sine_ff;
      shift_x_in     = shift_x_ff;
      shift_y_in     = shift_y_ff;
      cells_per_m_in = cells_per_m_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_YAW_COSINE:  yaw_cosine_in  = csr_data;
            CSR_YAW_SINE:    yaw_sine_in    = csr_data;
            CSR_SHIFT_X:     shift_x_in     = csr_data;
            CSR_SHIFT_Y:     shift_y_in     = csr_data;
            CSR_CELLS_PER_M: cells_per_m_in = csr_data;
            default: ;  // drop writes past the register list
         endcase
      end
   end

   //-------------------------------------------------------------------------
   // Source point and blend weights
   //-------------------------------------------------------------------------
   // Integer part is an arithmetic shift, i.e. floor; fraction truncates to Q.15.
   assign x0 = sx_ff[SXW-1:30];
   assign y0 = sy_ff[SXW-1:30];
   assign fx = sx_ff[29:15];
   assign fy = sy_ff[29:15];
   assign gx = 16'h8000 - 16'(fx);
   assign gy = 16'h8000 - 16'(fy);

   // Neighbor order over the weight steps: (x0,y0) (x0+1,y0) (x0,y0+1) (x0+1,y0+1)
   assign nbr = step_ff[1:0] + 2'd1;
   assign nx  = 21'(x0) + 21'(nbr[0]);
   assign ny  = 21'(y0) + 21'(nbr[1]);

   always_comb begin
      inside_in = !nx[20] && !ny[20] &&
                  (nx[19:0] < 20'(GRID_CELLS)) && (ny[19:0] < 20'(GRID_CELLS));
      mem_raddr = {IW'(ny), IW'(nx)};
   end

   //-------------------------------------------------------------------------
   // Shared multiplier: operand select
   //-------------------------------------------------------------------------
   always_comb begin
      unique case (step_ff)
         STEP_MX: begin
            mul_a = 17'(shift_x_ff);
            mul_b = 18'(cells_per_m_ff);
         end
         STEP_MY: begin
            mul_a = 17'(shift_y_ff);
            mul_b = 18'(cells_per_m_ff);
         end
         STEP_CUL: begin
            mul_a = 17'(yaw_cosine_ff);
            mul_b = 18'(u_ff[16:0]);
         end
         STEP_CUH: begin
            mul_a = 17'(yaw_cosine_ff);
            mul_b = 18'($signed(u_ff[UW-1:17]));
         end
         STEP_SUL: begin
            mul_a = 17'(yaw_sine_ff);
            mul_b = 18'(u_ff[16:0]);
         end
         STEP_SUH: begin
            mul_a = 17'(yaw_sine_ff);
            mul_b = 18'($signed(u_ff[UW-1:17]));
         end
         STEP_SVL: begin
            mul_a = 17'(yaw_sine_ff);
            mul_b = 18'(v_ff[16:0]);
         end
         STEP_SVH: begin
            mul_a = 17'(yaw_sine_ff);
            mul_b = 18'($signed(v_ff[UW-1:17]));
         end
         STEP_CVL: begin
            mul_a = 17'(yaw_cosine_ff);
            mul_b = 18'(v_ff[16:0]);
         end
         STEP_CVH: begin
            mul_a = 17'(yaw_cosine_ff);
            mul_b = 18'($signed(v_ff[UW-1:17]));
         end
         STEP_W00: begin
            mul_a = 17'(gx);
            mul_b = 18'(gy);
         end
         STEP_W10: begin
            mul_a = 17'(fx);
            mul_b = 18'(gy);
         end
         STEP_W01: begin
            mul_a = 17'(gx);
            mul_b = 18'(fy);
         end
         STEP_W11: begin
            mul_a = 17'(fx);
            mul_b = 18'(fy);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   //-------------------------------------------------------------------------
   // Product consumers
   //-------------------------------------------------------------------------
   assign p_ext = SXW'(prod_ff);

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      acc_in      = acc_ff;
      rsp_word_in = rsp_word_ff;
      // high halves of the split operand weigh 2**17
      p_term      = step_ff[0] ? p_ext : (p_ext <<< 17);
      if (start) begin
         x_in  = req_word.cell_x;
         y_in  = req_word.cell_y;
         sx_in = '0;
         sy_in = '0;
         acc_in = '0;
      end else if (state_ff == ST_WARP) begin
         unique case (step_ff)
            STEP_MY:     u_in  = UW'($signed({1'b0, x_ff, 16'b0})) + UW'(prod_ff);
            STEP_CUL:    v_in  = UW'($signed({1'b0, y_ff, 16'b0})) + UW'(prod_ff);
            STEP_CUH,
            STEP_SUL:    sx_in = sx_ff + p_term;
            STEP_SUH,
            STEP_SVL:    sy_in = sy_ff + p_term;
            STEP_SVH,
            STEP_CVL:    sx_in = sx_ff - p_term;
            STEP_CVH,
            STEP_SETTLE: sy_in = sy_ff + p_term;
            STEP_W10,
            STEP_W01,
            STEP_W11,
            STEP_LAST: begin
               // add the weight of an occupied in-grid neighbor
               if (cell_ff && inside_ff) begin
                  acc_in = acc_ff + prod_ff[ACCW-1:0];
               end
            end
            default: ;
         endcase
      end
      if (load_rsp) begin
         // round half up to Q1.15
         rsp_word_in.warped_value = VALUE_W'((acc_ff + ACCW'(16384)) >> 15);
         rsp_word_in.out_x        = x_ff;
         rsp_word_in.out_y        = y_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   //-------------------------------------------------------------------------
   // Registers
   //-------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         step_ff        <= STEP_MX;
         clr_ptr_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         yaw_cosine_ff  <= YAW_COSINE_RST;
         yaw_sine_ff    <= YAW_SINE_RST;
         shift_x_ff     <= SHIFT_X_RST;
         shift_y_ff     <= SHIFT_Y_RST;
         cells_per_m_ff <= CELLS_PER_M_RST;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         clr_ptr_ff     <= clr_ptr_in;
         rsp_valid_ff   <= rsp_valid_in;
         yaw_cosine_ff  <= yaw_cosine_in;
         yaw_sine_ff    <= yaw_sine_in;
         shift_x_ff     <= shift_x_in;
         shift_y_ff     <= shift_y_in;
         cells_per_m_ff <= cells_per_m_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      inside_ff   <= inside_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Grid memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      cell_ff <= grid_mem[mem_raddr];
   end

   //-------------------------------------------------------------------------
   // Assertions
   //-------------------------------------------------------------------------
   // An accepted sample starts the step sequence at its first step
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_word.req_type == REQ_SAMPLE)
         |=> (state_ff == ST_WARP && step_ff == STEP_MX))
      else $error("sample accepted without starting the warp sequence");

   // The grid stays untouched while a sample is in flight
   a_no_write_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WARP || state_ff == ST_DONE) |-> !mem_we)
      else $error("grid written during a sample");

   // Blended occupancy never exceeds one
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.warped_value <= 16'd32768))
      else $error("warped value above one");

   // A finished result waits while the output register is stalled
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("result left the done state while output was stalled");

endmodule
